// ===== rtl/sumck_pkg.sv =====
// shared constants and result word type for the sum-checked frame parser
package sumck_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned HALF_W = 16;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'h3a;

   // result kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [HALF_W-1:0] frame_address;
      logic [HALF_W-1:0] function_code;
      logic [HALF_W-1:0] frame_length;
      logic              checksum_ok;
   } rsp_word_type;

endpackage

// ===== rtl/sum_checked_frame_parser.sv =====
// top level of the sum-checked frame parser
//
//   channel  dir  ports                                   one word
//   req      in   req_valid req_stall req_rx_byte         one received byte
//   rsp      out  rsp_valid rsp_stall rsp_kind ...        payload byte or frame end
//
// one byte is taken every cycle while req_stall is low; the parse step is combinational logic
// between the parse state registers and the result register
// a result reaches rsp from the result register, passing through the skid entry first if rsp is stalled
// reset (synchronous, active high) returns the parser to waiting for start
// a stalled result waits in the result register; one more result word still
// goes into the skid entry, after which req_stall rises until rsp takes a word
module sum_checked_frame_parser import sumck_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [HALF_W-1:0] rsp_frame_address,
   output logic [HALF_W-1:0] rsp_function_code,
   output logic [HALF_W-1:0] rsp_frame_length,
   output logic              rsp_checksum_ok
);

   logic         accept;
   logic         buf_full;
   logic         res_valid;
   rsp_word_type res_word;
   rsp_word_type out_word;

   // stall only once the skid entry holds a word
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // header capture, payload count and running sum
   sumck_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // result register plus skid so input keeps flowing while rsp is stalled
   sumck_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_word   (res_word),
      .in_full   (buf_full),
      .out_valid (rsp_valid),
      .out_word  (out_word),
      .out_stall (rsp_stall)
   );

   assign rsp_kind          = out_word.kind;
   assign rsp_payload_byte  = out_word.payload_byte;
   assign rsp_frame_address = out_word.frame_address;
   assign rsp_function_code = out_word.function_code;
   assign rsp_frame_length  = out_word.frame_length;
   assign rsp_checksum_ok   = out_word.checksum_ok;

endmodule

// ===== rtl/sumck_parse.sv =====
// frame parse state machine with running header and payload sum
module sumck_parse import sumck_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] rx_byte,
   output logic              res_valid,
   output rsp_word_type      res_word
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ADDR0 = 4'd1,
      PH_ADDR1 = 4'd2,
      PH_FUNC0 = 4'd3,
      PH_FUNC1 = 4'd4,
      PH_LEN0  = 4'd5,
      PH_LEN1  = 4'd6,
      PH_DATA  = 4'd7,
      PH_SUM1  = 4'd8
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [HALF_W-1:0] addr_ff, addr_in;
   logic [HALF_W-1:0] func_ff, func_in;
   logic [HALF_W-1:0] len_ff, len_in;
   logic [HALF_W-1:0] left_ff, left_in;
   logic [HALF_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] sum_lo_ff, sum_lo_in;
   logic [HALF_W-1:0] rx_sum;
   logic [HALF_W-1:0] len_full;

   assign rx_sum   = {rx_byte, sum_lo_ff};
   assign len_full = {rx_byte, len_ff[BYTE_W-1:0]};

   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      sum_lo_in = sum_lo_ff;
      res_valid = 1'b0;
      res_word.kind          = KIND_PAYLOAD;
      res_word.payload_byte  = '0;
      res_word.frame_address = addr_ff;
      res_word.function_code = func_ff;
      res_word.frame_length  = len_ff;
      res_word.checksum_ok   = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (rx_byte == START_BYTE) phase_in = PH_ADDR0;
            end
            PH_ADDR0: begin
               addr_in  = {{(HALF_W-BYTE_W){1'b0}}, rx_byte};
               phase_in = PH_ADDR1;
            end
            PH_ADDR1: begin
               addr_in  = {rx_byte, addr_ff[BYTE_W-1:0]};
               phase_in = PH_FUNC0;
            end
            PH_FUNC0: begin
               func_in  = {{(HALF_W-BYTE_W){1'b0}}, rx_byte};
               phase_in = PH_FUNC1;
            end
            PH_FUNC1: begin
               func_in  = {rx_byte, func_ff[BYTE_W-1:0]};
               phase_in = PH_LEN0;
            end
            PH_LEN0: begin
               len_in   = {{(HALF_W-BYTE_W){1'b0}}, rx_byte};
               phase_in = PH_LEN1;
            end
            PH_LEN1: begin
               len_in   = len_full;
               left_in  = len_full;
               sum_in   = addr_ff + func_ff + len_full;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               if (left_ff == '0) begin
                  sum_lo_in = rx_byte;
                  phase_in  = PH_SUM1;
               end else begin
                  sum_in    = sum_ff + {{(HALF_W-BYTE_W){1'b0}}, rx_byte};
                  left_in   = left_ff - HALF_W'(1);
                  res_valid = 1'b1;
                  res_word.payload_byte = rx_byte;
               end
            end
            PH_SUM1: begin
               phase_in  = PH_IDLE;
               res_valid = 1'b1;
               res_word.kind        = KIND_FRAME_END;
               res_word.checksum_ok = (rx_sum == sum_ff);
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         addr_ff   <= '0;
         func_ff   <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         sum_ff    <= '0;
         sum_lo_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         addr_ff   <= addr_in;
         func_ff   <= func_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         sum_ff    <= sum_in;
         sum_lo_ff <= sum_lo_in;
      end
   end

endmodule

// ===== rtl/sumck_out_buf.sv =====
// result register with one skid entry
module sumck_out_buf import sumck_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rsp_word_type in_word,
   output logic         in_full,
   output logic         out_valid,
   output rsp_word_type out_word,
   input  logic         out_stall
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type main_ff, main_in;
   rsp_word_type skid_ff, skid_in;
   logic         take;

   assign take      = main_valid_ff && !out_stall;
   assign in_full   = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            main_in = in_word;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff) begin
            main_in       = in_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
